FILE: hdl/bfiq_pkg.sv
package bfiq_pkg;

	// Store geometry
	localparam int MAX_BITS    = 65536;
	localparam int MAX_HASHES  = 16;
	localparam int SECOND_SHIFT = 16;
	localparam int POS_W       = $clog2(MAX_BITS);
	localparam int DIV_W       = POS_W + 1;
	localparam int ROW_W       = 64;
	localparam int ROW_SEL_W   = $clog2(ROW_W);
	localparam int ROWS        = MAX_BITS / ROW_W;
	localparam int ROW_IDX_W   = POS_W - ROW_SEL_W;

	// Field and register widths
	localparam int HASH_W      = 32;
	localparam int KIND_W      = 2;
	localparam int NUMH_W      = 5;
	localparam int BITC_W      = 17;
	localparam int CFG_IDX_W   = 1;
	localparam int OUT_W       = 8;
	localparam int HCNT_W      = $clog2(MAX_HASHES + 1);

	// Probe value after sign folding has its top bit clear
	localparam int C_W         = HASH_W - 1;
	localparam int DCNT_W      = $clog2(C_W);

	localparam logic [NUMH_W-1:0] NUMH_RESET = NUMH_W'(7);
	localparam logic [BITC_W-1:0] BITC_RESET = BITC_W'(65536);

	localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TEST  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_NOP   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 1'd1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CALC,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

FILE: hdl/bloom_filter_insert_query.sv
// Bloom filter with double hashing over a 64K-bit store held as 1024 rows of 64 bits.
// Each word carries a 32-bit hash in s_tdata and the operation in s_tuser (add, test,
// clear, nop); one result word with the present flag comes back for every input word.
// The block works on one word at a time and drops s_tready while busy. Each probe
// runs an add of the second hash, a shared bit-serial remainder unit against the bit
// count, one store read and one check or write-back. An add runs every probe, a test
// stops at the first clear bit, and a clear sweeps the store one row a cycle.
// After reset the same sweep runs before the first word is taken.
// Configuration writes are taken at any time and should be made while idle.
module bloom_filter_insert_query (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [bfiq_pkg::HASH_W-1:0]       s_tdata,   // [31:0] hash
	input  logic [bfiq_pkg::KIND_W-1:0]       s_tuser,   // [1:0] kind
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [bfiq_pkg::OUT_W-1:0]        m_tdata,   // [0] present, rest zero
	input  logic                              cfg_we,
	input  logic [bfiq_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [bfiq_pkg::BITC_W-1:0]       cfg_wdata
);

	bfiq_pkg::state_t state_q, state_d;

	logic [bfiq_pkg::NUMH_W-1:0]    num_hashes_q;
	logic [bfiq_pkg::BITC_W-1:0]    bit_count_q;

	logic [bfiq_pkg::KIND_W-1:0]    kind_q;
	logic [bfiq_pkg::HASH_W-1:0]    acc_q;
	logic [bfiq_pkg::HASH_W-1:0]    step_q;
	logic [bfiq_pkg::HCNT_W-1:0]    probes_q;
	logic [bfiq_pkg::DIV_W-1:0]     divisor_q;
	logic [bfiq_pkg::C_W-1:0]       dvd_q;
	logic [bfiq_pkg::DIV_W-1:0]     rem_q;
	logic [bfiq_pkg::DCNT_W-1:0]    dcnt_q;
	logic                           all_q;
	logic                           clr_reply_q;
	logic [bfiq_pkg::ROW_IDX_W-1:0] clr_row_q;
	logic [bfiq_pkg::ROW_W-1:0]     rd_row_q;
	logic                           out_valid_q;
	logic                           present_q;

	logic [bfiq_pkg::ROW_W-1:0]     store_mem [bfiq_pkg::ROWS];

	logic                           accept;
	logic                           load_out;
	logic [bfiq_pkg::HCNT_W-1:0]    eff_hashes;
	logic [bfiq_pkg::DIV_W-1:0]     eff_bits;
	logic [bfiq_pkg::HASH_W-1:0]    probe_sum;
	logic [bfiq_pkg::DIV_W:0]       trial;
	logic                           trial_ge;
	logic [bfiq_pkg::DIV_W-1:0]     rem_next;
	logic [bfiq_pkg::POS_W-1:0]     pos;
	logic [bfiq_pkg::ROW_W-1:0]     bit_mask;
	logic                           probe_bit;
	logic                           mem_we;
	logic [bfiq_pkg::ROW_IDX_W-1:0] mem_waddr;
	logic [bfiq_pkg::ROW_W-1:0]     mem_wdata;

	assign s_tready = (state_q == bfiq_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(bfiq_pkg::OUT_W - 1)'(0), present_q};

	// Saturated copies of the registers, sampled when a word is taken
	always_comb begin
		if (32'(num_hashes_q) > 32'(bfiq_pkg::MAX_HASHES)) begin
			eff_hashes = bfiq_pkg::HCNT_W'(bfiq_pkg::MAX_HASHES);
		end else begin
			eff_hashes = bfiq_pkg::HCNT_W'(num_hashes_q);
		end
		if (bit_count_q == '0) begin
			eff_bits = bfiq_pkg::DIV_W'(1);
		end else if (32'(bit_count_q) > 32'(bfiq_pkg::MAX_BITS)) begin
			eff_bits = bfiq_pkg::DIV_W'(bfiq_pkg::MAX_BITS);
		end else begin
			eff_bits = bfiq_pkg::DIV_W'(bit_count_q);
		end
	end

	assign probe_sum = acc_q + step_q;

	// One restoring remainder step a cycle
	assign trial    = {rem_q, dvd_q[bfiq_pkg::C_W-1]};
	assign trial_ge = trial >= {1'b0, divisor_q};
	assign rem_next = trial_ge ? bfiq_pkg::DIV_W'(trial - {1'b0, divisor_q})
	                           : trial[bfiq_pkg::DIV_W-1:0];

	assign pos       = rem_q[bfiq_pkg::POS_W-1:0];
	assign bit_mask  = bfiq_pkg::ROW_W'(1) << pos[bfiq_pkg::ROW_SEL_W-1:0];
	assign probe_bit = |(rd_row_q & bit_mask);

	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = pos[bfiq_pkg::POS_W-1:bfiq_pkg::ROW_SEL_W];
		mem_wdata = rd_row_q | bit_mask;
		unique case (state_q)
			bfiq_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_row_q;
				mem_wdata = '0;
				if (clr_row_q == '1) begin
					state_d = clr_reply_q ? bfiq_pkg::ST_DONE : bfiq_pkg::ST_IDLE;
				end
			end
			bfiq_pkg::ST_IDLE: begin
				if (accept) begin
					case (s_tuser) inside
						bfiq_pkg::KIND_ADD, bfiq_pkg::KIND_TEST: state_d = bfiq_pkg::ST_CALC;
						bfiq_pkg::KIND_CLEAR: state_d = bfiq_pkg::ST_CLEAR;
						default: state_d = bfiq_pkg::ST_DONE;
					endcase
				end
			end
			bfiq_pkg::ST_CALC: begin
				state_d = (probes_q == '0) ? bfiq_pkg::ST_DONE : bfiq_pkg::ST_DIV;
			end
			bfiq_pkg::ST_DIV: begin
				if (dcnt_q == '0) begin
					state_d = bfiq_pkg::ST_READ;
				end
			end
			bfiq_pkg::ST_READ: begin
				state_d = bfiq_pkg::ST_CHECK;
			end
			bfiq_pkg::ST_CHECK: begin
				if (kind_q == bfiq_pkg::KIND_ADD) begin
					mem_we  = 1'b1;
					state_d = bfiq_pkg::ST_CALC;
				end else if (!probe_bit) begin
					// stop the test at the first clear bit
					state_d = bfiq_pkg::ST_DONE;
				end else begin
					state_d = bfiq_pkg::ST_CALC;
				end
			end
			bfiq_pkg::ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = bfiq_pkg::ST_IDLE;
				end
			end
			default: state_d = bfiq_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfiq_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hashes_q <= bfiq_pkg::NUMH_RESET;
			bit_count_q  <= bfiq_pkg::BITC_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				bfiq_pkg::CFG_NUM_HASHES: num_hashes_q <= cfg_wdata[bfiq_pkg::NUMH_W-1:0];
				bfiq_pkg::CFG_BIT_COUNT:  bit_count_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q   <= '0;
			clr_reply_q <= 1'b0;
			out_valid_q <= 1'b0;
			probes_q    <= '0;
			dcnt_q      <= '0;
			all_q       <= 1'b0;
		end else begin
			if (state_q == bfiq_pkg::ST_CLEAR) begin
				clr_row_q <= clr_row_q + 1'b1;
			end
			if (accept) begin
				clr_reply_q <= (s_tuser == bfiq_pkg::KIND_CLEAR);
				probes_q    <= eff_hashes;
				all_q       <= 1'b1;
			end
			if (state_q == bfiq_pkg::ST_CALC && probes_q != '0) begin
				probes_q <= probes_q - 1'b1;
				dcnt_q   <= bfiq_pkg::DCNT_W'(bfiq_pkg::C_W - 1);
			end
			if (state_q == bfiq_pkg::ST_DIV) begin
				dcnt_q <= dcnt_q - 1'b1;
			end
			if (state_q == bfiq_pkg::ST_CHECK && kind_q == bfiq_pkg::KIND_TEST && !probe_bit) begin
				all_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q    <= s_tuser;
			acc_q     <= s_tdata;
			step_q    <= bfiq_pkg::HASH_W'($signed(s_tdata) >>> bfiq_pkg::SECOND_SHIFT);
			divisor_q <= eff_bits;
		end
		if (state_q == bfiq_pkg::ST_CALC) begin
			acc_q <= probe_sum;
			// fold negative values by inversion
			dvd_q <= probe_sum[bfiq_pkg::HASH_W-1] ? ~probe_sum[bfiq_pkg::C_W-1:0]
			                                       : probe_sum[bfiq_pkg::C_W-1:0];
			rem_q <= '0;
		end
		if (state_q == bfiq_pkg::ST_DIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[bfiq_pkg::C_W-2:0], 1'b0};
		end
		if (load_out) begin
			present_q <= (kind_q == bfiq_pkg::KIND_TEST) && all_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (state_q == bfiq_pkg::ST_READ) begin
			rd_row_q <= store_mem[pos[bfiq_pkg::POS_W-1:bfiq_pkg::ROW_SEL_W]];
		end
	end

endmodule

FILE: hdl/bfiq_checker.sv
module bfiq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [bfiq_pkg::OUT_W-1:0]     m_tdata
);

	// A taken word keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a word");

	// A result never appears in the cycle right after a word is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
		else $error("result appeared too early");

	// Padding bits of the result word stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[bfiq_pkg::OUT_W-1:1] == '0))
		else $error("result padding not zero");

	// A stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: tb/sv/bloom_filter_insert_query_tb.sv
module bloom_filter_insert_query_tb;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [bfiq_pkg::HASH_W-1:0]    s_tdata = '0;   // [31:0] hash
	logic [bfiq_pkg::KIND_W-1:0]    s_tuser = '0;   // [1:0] kind
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [bfiq_pkg::OUT_W-1:0]     m_tdata;        // [0] present, rest zero
	logic                           cfg_we = 1'b0;
	logic [bfiq_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
	logic [bfiq_pkg::BITC_W-1:0]    cfg_wdata = '0;

	bloom_filter_insert_query DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	typedef struct {
		logic [bfiq_pkg::KIND_W-1:0] kind;
		logic [bfiq_pkg::HASH_W-1:0] hash;
		logic                        present;
	} lookup_t;

	typedef enum {ROW_WORD, ROW_CFG} row_op_t;
	typedef enum {WANT_0, WANT_1, WANT_PRED} want_t;

	typedef struct {
		row_op_t                        op;
		logic [bfiq_pkg::KIND_W-1:0]    kind;
		logic [31:0]                    arg;    // hash, or register value
		logic [bfiq_pkg::CFG_IDX_W-1:0] addr;
		want_t                          want;
	} row_t;

	localparam int N_ROWS = 34;

	row_t plan [N_ROWS] = '{
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_ADD,   32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_WORD, bfiq_pkg::KIND_ADD,   32'h7FFF_FFFF, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h7FFF_FFFF, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_WORD, bfiq_pkg::KIND_ADD,   32'h8000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h8000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'hFFFF_FFFF, bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_NOP,   32'h1234_5678, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_WORD, bfiq_pkg::KIND_CLEAR, 32'hA5A5_A5A5, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h7FFF_FFFF, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		// no probes at all: test always hits, add leaves the store alone
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd0,         bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h1357_9BDF, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_WORD, bfiq_pkg::KIND_ADD,   32'h1357_9BDF, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		// both registers above their ceilings
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd31,        bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd131071,    bfiq_pkg::CFG_BIT_COUNT,  WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_ADD,   32'hDEAD_BEEF, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'hDEAD_BEEF, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'hDEAD_BEEE, bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		// zero bit count folds every probe onto position 0
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd0,         bfiq_pkg::CFG_BIT_COUNT,  WANT_PRED},
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd3,         bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_ADD,   32'h5555_5555, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'hAAAA_AAAA, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd1,         bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd65536,     bfiq_pkg::CFG_BIT_COUNT,  WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_1},
		// clear must also wipe bits above a small bit count
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd64,        bfiq_pkg::CFG_BIT_COUNT,  WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_CLEAR, 32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd16,        bfiq_pkg::CFG_NUM_HASHES, WANT_PRED},
		'{ROW_CFG,  bfiq_pkg::KIND_ADD,   32'd65536,     bfiq_pkg::CFG_BIT_COUNT,  WANT_PRED},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'hDEAD_BEEF, bfiq_pkg::CFG_NUM_HASHES, WANT_0},
		'{ROW_WORD, bfiq_pkg::KIND_TEST,  32'h0000_0000, bfiq_pkg::CFG_NUM_HASHES, WANT_0}
	};

	bit                          filt [bfiq_pkg::MAX_BITS];
	logic [bfiq_pkg::NUMH_W-1:0] hashes_cfg = bfiq_pkg::NUMH_RESET;
	logic [bfiq_pkg::BITC_W-1:0] bits_cfg = bfiq_pkg::BITC_RESET;

	lookup_t                     pending_q [$];
	logic [bfiq_pkg::HASH_W-1:0] added_q [$];
	int                          errors = 0;
	int                          hold = 0;
	bit                          quiet = 1'b0;

	function automatic int unsigned probe_pos(logic [31:0] h, int unsigned i,
			int unsigned div);
		logic [31:0] g;
		logic [31:0] c;
		g = $signed(h) >>> bfiq_pkg::SECOND_SHIFT;
		c = h + i * g;
		if (c[31])
			c = ~c;
		return c % div;
	endfunction

	// Update the filter copy and return the present flag for one word
	function automatic logic bloom_apply(logic [bfiq_pkg::KIND_W-1:0] kind,
			logic [bfiq_pkg::HASH_W-1:0] h);
		int unsigned k;
		int unsigned div;
		logic        hit;
		k = (hashes_cfg > bfiq_pkg::MAX_HASHES) ? bfiq_pkg::MAX_HASHES : hashes_cfg;
		div = (bits_cfg == 0) ? 1 :
			((bits_cfg > bfiq_pkg::MAX_BITS) ? bfiq_pkg::MAX_BITS : bits_cfg);
		hit = 1'b1;
		case (kind)
			bfiq_pkg::KIND_ADD: begin
				for (int unsigned i = 1; i <= k; i++)
					filt[probe_pos(h, i, div)] = 1'b1;
				return 1'b0;
			end
			bfiq_pkg::KIND_TEST: begin
				for (int unsigned i = 1; i <= k; i++)
					if (!filt[probe_pos(h, i, div)])
						hit = 1'b0;
				return hit;
			end
			bfiq_pkg::KIND_CLEAR: begin
				foreach (filt[j])
					filt[j] = 1'b0;
				return 1'b0;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic send_word(input logic [bfiq_pkg::KIND_W-1:0] kind,
			input logic [bfiq_pkg::HASH_W-1:0] h, input logic known, input logic want_bit);
		int      gap;
		lookup_t w;
		gap = quiet ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = kind;
		s_tdata = h;
		do @(posedge clk); while (!s_tready);
		w.kind = kind;
		w.hash = h;
		w.present = bloom_apply(kind, h);
		if (known)
			w.present = want_bit;
		pending_q.push_back(w);
	endtask

	// Write only once every pending word has come back
	task automatic write_reg(input logic [bfiq_pkg::CFG_IDX_W-1:0] idx,
			input logic [bfiq_pkg::BITC_W-1:0] val);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_q.size() != 0)
			@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		case (idx)
			bfiq_pkg::CFG_NUM_HASHES: hashes_cfg = val[bfiq_pkg::NUMH_W-1:0];
			bfiq_pkg::CFG_BIT_COUNT:  bits_cfg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold > 0) begin
			m_tready = 1'b0;
			hold--;
		end else begin
			m_tready = 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				hold = pick_gap();
		end
	end

	always @(posedge clk) begin
		lookup_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("result word 0x%0h with nothing pending", m_tdata));
			end else begin
				e = pending_q.pop_front();
				if (m_tdata !== bfiq_pkg::OUT_W'(e.present))
					report_mismatch($sformatf(
						"kind %0d hash 0x%08h: present got 0x%0h want %0b",
						e.kind, e.hash, m_tdata, e.present));
			end
		end
	end

	initial begin
		int unsigned                 nh;
		int unsigned                 bc;
		int                          r;
		logic [bfiq_pkg::KIND_W-1:0] kind;
		logic [bfiq_pkg::HASH_W-1:0] h;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].op == ROW_CFG)
				write_reg(plan[i].addr, plan[i].arg[bfiq_pkg::BITC_W-1:0]);
			else
				send_word(plan[i].kind, plan[i].arg, plan[i].want != WANT_PRED,
					plan[i].want == WANT_1);
		end

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin nh = 16; bc = 65536; end
				1: begin nh = 1;  bc = 131071; end
				2: begin nh = 31; bc = 64; end
				3: begin nh = 4;  bc = 1; end
				4: begin nh = 0;  bc = 1000; end
				5: begin nh = 7;  bc = 0; end
				default: begin
					nh = $urandom_range(0, 31);
					bc = $urandom_range(0, 1) ? $urandom_range(1, 3000)
					                          : $urandom_range(0, 131071);
				end
			endcase
			write_reg(bfiq_pkg::CFG_NUM_HASHES, bfiq_pkg::BITC_W'(nh));
			write_reg(bfiq_pkg::CFG_BIT_COUNT, bfiq_pkg::BITC_W'(bc));
			quiet = (ph % 4 == 3);
			for (int n = 0; n < 63; n++) begin
				r = $urandom_range(0, 99);
				h = $urandom;
				if (r < 45) begin
					kind = bfiq_pkg::KIND_ADD;
					added_q.push_back(h);
					if (added_q.size() > 64)
						void'(added_q.pop_front());
				end else if (r < 92) begin
					kind = bfiq_pkg::KIND_TEST;
					// mostly probe keys already added so hits show up
					if (added_q.size() != 0 && $urandom_range(0, 9) < 7)
						h = added_q[$urandom_range(0, added_q.size() - 1)];
				end else if (r < 96) begin
					kind = bfiq_pkg::KIND_NOP;
				end else begin
					kind = bfiq_pkg::KIND_CLEAR;
					added_q.delete();
				end
				send_word(kind, h, 1'b0, 1'b0);
			end
		end
		quiet = 1'b0;

		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#8000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
